[hw/rtl/gss_pkg.sv]
// ----------------------------------------------------------------------------
// gss_pkg
// Shared constants, codes, types and the kernel weight table of the star
// splatting core.
// ----------------------------------------------------------------------------
`default_nettype none

package gss_pkg;

   // accumulator memory geometry
   localparam int unsigned MEM_COLS = 256;
   localparam int unsigned MEM_ROWS = 256;
   localparam int unsigned COL_W    = $clog2(MEM_COLS);
   localparam int unsigned ROW_W    = $clog2(MEM_ROWS);
   localparam int unsigned ADDR_W   = COL_W + ROW_W;

   // field widths
   localparam int unsigned DIM_W      = 9;
   localparam int unsigned POSIN_W    = 32;
   localparam int unsigned ORIGIN_W   = 33;
   localparam int unsigned SCALE_W    = 36;
   localparam int unsigned FLUX_W     = 16;
   localparam int unsigned WGT_W      = 15;
   localparam int unsigned ACC_W      = 32;
   localparam int unsigned CNT_W      = 24;
   localparam int unsigned COORD_W    = 22;
   localparam int unsigned POS_W      = 24;
   localparam int unsigned COORD_LIMIT = 1 << 20;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // stream payload widths
   localparam int unsigned REQ_DATA_W = 112;
   localparam int unsigned RSP_DATA_W = 144;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 36;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORIGIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MEAN   = 3'd6;

   // item kinds
   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // tap position limits
   localparam logic [2:0] TAP_LAST = 3'd4;
   localparam logic [2:0] TAP_MID  = 3'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROJ_X,
      ST_WAIT_X,
      ST_WAIT_Y,
      ST_TEST,
      ST_TAPS,
      ST_DRAIN,
      ST_READ,
      ST_RDWAIT,
      ST_DONE
   } core_state_type;

   // one access to the accumulator memory
   typedef struct packed {
      logic              valid;
      logic              add;
      logic [ADDR_W-1:0] addr;
      logic [ACC_W-1:0]  red;
      logic [ACC_W-1:0]  green;
      logic [ACC_W-1:0]  blue;
   } acc_cmd_type;

   // 5x5 Gaussian weights, Q0.16, indexed by tap row and column 0..4
   function automatic logic [WGT_W-1:0] kern_weight(input logic [2:0] ty,
                                                    input logic [2:0] tx);
      logic [1:0]       ay;
      logic [1:0]       ax;
      logic [WGT_W-1:0] wt;
      ay = (ty >= TAP_MID) ? 2'(ty - TAP_MID) : 2'(TAP_MID - ty);
      ax = (tx >= TAP_MID) ? 2'(tx - TAP_MID) : 2'(TAP_MID - tx);
      case ({ay, ax})
         4'b0000:          wt = 15'd20862;
         4'b0001, 4'b0100: wt = 15'd7675;
         4'b0101:          wt = 15'd2823;
         4'b0010, 4'b1000: wt = 15'd382;
         4'b0110, 4'b1001: wt = 15'd141;
         4'b1010:          wt = 15'd7;
         default:          wt = '0;
      endcase
      return wt;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/gaussian_star_splat_core.sv]
// ----------------------------------------------------------------------------
// gaussian_star_splat_core
// Star splatting accumulator: projects a star to a pixel and adds its
// flux through a 5x5 Gaussian kernel into RGB accumulator memory, or
// reads back one pixel's sums.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+------------------------------
//   csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//   req     | in  | req_tvalid/req_tready | req_tdata, req_tuser (kind)
//   rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser
//
// A star that lands waits for the projections and the root unit, then
// walks 25 taps, one read-modify-write per cycle on the accumulator memory
// port, before the next accept. After reset all 65536 memory words are
// cleared while req_tready stays low. One item is in work at a time; a
// result waiting in the rsp register holds the next one only at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_star_splat_core import gss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // x_pos[31:0], y_pos[63:32], red_flux[79:64], blue_flux[95:80],
   // pixel_col[103:96], pixel_row[111:104]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // outside_total[23:0], inside_total[47:24], red_sum[79:48],
   // green_sum[111:80], blue_sum[143:112]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // star_inside[0]
   output logic [0:0]            rsp_tuser
);

   core_state_type state_ff, state_in;

   // configuration
   logic [DIM_W-1:0]    width_ff, height_ff;
   logic [ORIGIN_W-1:0] x_origin_ff, y_origin_ff;
   logic [SCALE_W-1:0]  x_scale_ff, y_scale_ff;
   logic                green_mean_ff;

   // item payload
   logic [POSIN_W-1:0] x_pos_ff, x_pos_in, y_pos_ff, y_pos_in;
   logic [FLUX_W-1:0]  red_ff, red_in, blue_ff, blue_in, green_ff, green_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic signed [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [2:0]         ty_ff, ty_in, tx_ff, tx_in;

   // result
   logic [CNT_W-1:0] outside_ff, outside_in, inside_ff, inside_in;
   logic             hit_ff, hit_in;
   logic [ACC_W-1:0] res_red_ff, res_red_in, res_green_ff, res_green_in;
   logic [ACC_W-1:0] res_blue_ff, res_blue_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_hit_ff, rsp_hit_in;

   // unit links
   logic                      proj_start, proj_busy;
   logic [POSIN_W-1:0]        proj_pos;
   logic [ORIGIN_W-1:0]       proj_origin;
   logic [SCALE_W-1:0]        proj_scale;
   logic signed [COORD_W-1:0] proj_coord;
   logic                      sqrt_start, sqrt_busy;
   logic [FLUX_W-1:0]         sqrt_root;
   acc_cmd_type               cmd;
   logic                      clearing;
   logic [ACC_W-1:0]          rd_red, rd_green, rd_blue;

   logic [DIM_W-1:0]        w_clamp, h_clamp;
   logic signed [POS_W-1:0] w_s, h_s, ix, iy;
   logic                    outside, tap_in;
   logic [WGT_W-1:0]        wt;
   logic                    req_xfer;

   assign w_clamp  = (width_ff > DIM_W'(MEM_COLS)) ? DIM_W'(MEM_COLS) : width_ff;
   assign h_clamp  = (height_ff > DIM_W'(MEM_ROWS)) ? DIM_W'(MEM_ROWS) : height_ff;
   assign w_s      = signed'(POS_W'(w_clamp));
   assign h_s      = signed'(POS_W'(h_clamp));
   assign req_xfer = req_tvalid && req_tready;

   // footprint test against the image
   assign outside = (px_ff + POS_W'(2) < 0) || (px_ff - POS_W'(2) >= w_s)
                 || (py_ff + POS_W'(2) < 0) || (py_ff - POS_W'(2) >= h_s);

   // current tap position
   assign iy     = py_ff + signed'(POS_W'(ty_ff)) - POS_W'(2);
   assign ix     = px_ff + signed'(POS_W'(tx_ff)) - POS_W'(2);
   assign tap_in = (iy >= 0) && (iy < h_s) && (ix >= 0) && (ix < w_s);
   assign wt     = kern_weight(ty_ff, tx_ff);

   assign proj_pos    = (state_ff == ST_PROJ_X) ? x_pos_ff : y_pos_ff;
   assign proj_origin = (state_ff == ST_PROJ_X) ? x_origin_ff : y_origin_ff;
   assign proj_scale  = (state_ff == ST_PROJ_X) ? x_scale_ff : y_scale_ff;
   assign proj_start  = (state_ff == ST_PROJ_X)
                     || (state_ff == ST_WAIT_X && !proj_busy);
   assign sqrt_start  = (state_ff == ST_PROJ_X);

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_W'(MEM_COLS);
         height_ff     <= DIM_W'(MEM_ROWS);
         x_origin_ff   <= '0;
         y_origin_ff   <= '0;
         x_scale_ff    <= SCALE_W'(65536);
         y_scale_ff    <= SCALE_W'(65536);
         green_mean_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff      <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff     <= csr_data[DIM_W-1:0];
            CSR_X_ORIGIN:     x_origin_ff   <= csr_data[ORIGIN_W-1:0];
            CSR_Y_ORIGIN:     y_origin_ff   <= csr_data[ORIGIN_W-1:0];
            CSR_X_SCALE:      x_scale_ff    <= csr_data;
            CSR_Y_SCALE:      y_scale_ff    <= csr_data;
            CSR_GREEN_MEAN:   green_mean_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      x_pos_in     = x_pos_ff;
      y_pos_in     = y_pos_ff;
      red_in       = red_ff;
      blue_in      = blue_ff;
      green_in     = green_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ty_in        = ty_ff;
      tx_in        = tx_ff;
      outside_in   = outside_ff;
      inside_in    = inside_ff;
      hit_in       = hit_ff;
      res_red_in   = res_red_ff;
      res_green_in = res_green_ff;
      res_blue_in  = res_blue_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      req_tready   = (state_ff == ST_IDLE) && !clearing;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_pos_in     = req_tdata[31:0];
               y_pos_in     = req_tdata[63:32];
               red_in       = req_tdata[79:64];
               blue_in      = req_tdata[95:80];
               col_in       = req_tdata[103:96];
               row_in       = req_tdata[111:104];
               hit_in       = 1'b0;
               res_red_in   = '0;
               res_green_in = '0;
               res_blue_in  = '0;
               state_in     = (req_tuser[0] == KIND_READ) ? ST_READ : ST_PROJ_X;
            end
         end
         ST_PROJ_X: begin
            state_in = ST_WAIT_X;
         end
         ST_WAIT_X: begin
            if (!proj_busy) begin
               px_in    = POS_W'(proj_coord);
               state_in = ST_WAIT_Y;
            end
         end
         ST_WAIT_Y: begin
            if (!proj_busy) begin
               py_in    = h_s - POS_W'(1) - POS_W'(proj_coord);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (outside) begin
               if (outside_ff != COUNT_MAX) begin
                  outside_in = outside_ff + 1'b1;
               end
               state_in = ST_DONE;
            end else if (!sqrt_busy) begin
               if (inside_ff != COUNT_MAX) begin
                  inside_in = inside_ff + 1'b1;
               end
               hit_in   = 1'b1;
               green_in = green_mean_ff
                        ? FLUX_W'(({1'b0, red_ff} + {1'b0, blue_ff}) >> 1) : sqrt_root;
               ty_in    = 3'd0;
               tx_in    = 3'd0;
               state_in = ST_TAPS;
            end
         end
         ST_TAPS: begin
            cmd.valid = tap_in;
            cmd.add   = 1'b1;
            cmd.addr  = {iy[ROW_W-1:0], ix[COL_W-1:0]};
            cmd.red   = ACC_W'(red_ff) * ACC_W'(wt);
            cmd.green = ACC_W'(green_ff) * ACC_W'(wt);
            cmd.blue  = ACC_W'(blue_ff) * ACC_W'(wt);
            if (tx_ff == TAP_LAST) begin
               tx_in = 3'd0;
               ty_in = ty_ff + 3'd1;
               if (ty_ff == TAP_LAST) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               tx_in = tx_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_READ: begin
            cmd.valid = 1'b1;
            cmd.addr  = {row_ff, col_ff};
            state_in  = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            res_red_in   = rd_red;
            res_green_in = rd_green;
            res_blue_in  = rd_blue;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_data_in  = {res_blue_ff, res_green_ff, res_red_ff,
                               inside_ff, outside_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         outside_ff   <= '0;
         inside_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         outside_ff   <= outside_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_pos_ff     <= x_pos_in;
      y_pos_ff     <= y_pos_in;
      red_ff       <= red_in;
      blue_ff      <= blue_in;
      green_ff     <= green_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      ty_ff        <= ty_in;
      tx_ff        <= tx_in;
      hit_ff       <= hit_in;
      res_red_ff   <= res_red_in;
      res_green_ff <= res_green_in;
      res_blue_ff  <= res_blue_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

   gss_proj u_proj (
      .clock  (clock),
      .reset  (reset),
      .start  (proj_start),
      .pos    (proj_pos),
      .origin (proj_origin),
      .scale  (proj_scale),
      .busy   (proj_busy),
      .coord  (proj_coord)
   );

   gss_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .red   (red_ff),
      .blue  (blue_ff),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   gss_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .clearing (clearing),
      .rd_red   (rd_red),
      .rd_green (rd_green),
      .rd_blue  (rd_blue)
   );

endmodule

`default_nettype wire

[hw/rtl/gss_proj.sv]
// ----------------------------------------------------------------------------
// gss_proj
// Projection unit: floor((pos - origin) * scale / 2^40), saturated to
// +-2^20; the low product, the high terms and the rounded result are registered in turn, with one 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_proj import gss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [POSIN_W-1:0]        pos,
   input  logic [ORIGIN_W-1:0]       origin,
   input  logic [SCALE_W-1:0]        scale,
   output logic                      busy,
   output logic signed [COORD_W-1:0] coord
);

   logic                      busy_ff, busy_in;
   logic [1:0]                step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic [ORIGIN_W-1:0]       mag_ff, mag_in;
   logic [SCALE_W-1:0]        scale_ff, scale_in;
   logic [68:0]               prod_ff, prod_in;
   logic signed [COORD_W-1:0] coord_ff, coord_in;

   logic [ORIGIN_W:0]  diff;
   logic [63:0]        lo_prod;
   logic [35:0]        mid_prod;
   logic [68:0]        hi_term;
   logic [28:0]        quo;
   logic               frac;
   logic [20:0]        quo_sat;
   logic [COORD_W-1:0] neg_val;

   // signed difference and its magnitude
   assign diff = {2'b00, pos} - {origin[ORIGIN_W-1], origin};

   assign lo_prod  = 64'(mag_ff[31:0]) * 64'(scale_ff[31:0]);
   assign mid_prod = 36'(mag_ff[31:0]) * 36'(scale_ff[35:32]);
   assign hi_term  = {1'b0, mid_prod, 32'b0}
                   + (mag_ff[32] ? {1'b0, scale_ff, 32'b0} : 69'b0);

   // rounding toward minus infinity and saturation
   assign quo     = prod_ff[68:40];
   assign frac    = |prod_ff[39:0];
   assign quo_sat = (quo > 29'(COORD_LIMIT)) ? 21'(COORD_LIMIT) : quo[20:0];
   assign neg_val = (quo_sat == 21'(COORD_LIMIT)) ? -(COORD_W'(quo_sat))
                  : -(COORD_W'(quo_sat)) - COORD_W'(frac);

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      scale_in = scale_ff;
      prod_in  = prod_ff;
      coord_in = coord_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = 2'd1;
         neg_in   = diff[ORIGIN_W];
         mag_in   = diff[ORIGIN_W] ? ORIGIN_W'(-diff) : diff[ORIGIN_W-1:0];
         scale_in = scale;
      end else if (busy_ff) begin
         case (step_ff)
            2'd1: begin
               prod_in = {5'b0, lo_prod};
               step_in = 2'd2;
            end
            2'd2: begin
               prod_in = prod_ff + hi_term;
               step_in = 2'd3;
            end
            default: begin
               coord_in = neg_ff ? signed'(neg_val) : signed'(COORD_W'(quo_sat));
               busy_in  = 1'b0;
               step_in  = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      scale_ff <= scale_in;
      prod_ff  <= prod_in;
      coord_ff <= coord_in;
   end

   assign busy  = busy_ff;
   assign coord = coord_ff;

endmodule

`default_nettype wire

[hw/rtl/gss_sqrt.sv]
// ----------------------------------------------------------------------------
// gss_sqrt
// Geometric mean of red and blue flux: floor(sqrt(red*blue)), one result
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_sqrt import gss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FLUX_W-1:0] red,
   input  logic [FLUX_W-1:0] blue,
   output logic              busy,
   output logic [FLUX_W-1:0] root
);

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;

   logic [31:0] bit_val;
   logic [31:0] trial;

   assign bit_val = 32'h4000_0000 >> {cnt_ff, 1'b0};
   assign trial   = res_ff + bit_val;

   // restoring square root, two radicand bits per step
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         rem_in  = 32'(red) * 32'(blue);
         res_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_val;
         end else begin
            res_in = res_ff >> 1;
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'hF) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[FLUX_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/gss_accum.sv]
// ----------------------------------------------------------------------------
// gss_accum
// RGB accumulator memory: one 96-bit word per pixel, registered read,
// saturating read-modify-write in the cycle after the read, clearing pass
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_accum import gss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  acc_cmd_type      cmd,
   output logic             clearing,
   output logic [ACC_W-1:0] rd_red,
   output logic [ACC_W-1:0] rd_green,
   output logic [ACC_W-1:0] rd_blue
);

   localparam int unsigned WORD_W = 3 * ACC_W;

   logic [WORD_W-1:0] mem [MEM_COLS * MEM_ROWS];

   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              pend_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [WORD_W-1:0] pend_add_ff;
   logic [WORD_W-1:0] rdata_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? '1 : s[ACC_W-1:0];
   endfunction

   // clearing sweep, one word a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // write port: clear or the pending tap update
   always_comb begin
      wr_en   = clr_busy_ff || pend_ff;
      wr_addr = clr_busy_ff ? clr_addr_ff : pend_addr_ff;
      wr_data = '0;
      if (!clr_busy_ff) begin
         wr_data = {sat_add(rdata_ff[3*ACC_W-1:2*ACC_W], pend_add_ff[3*ACC_W-1:2*ACC_W]),
                    sat_add(rdata_ff[2*ACC_W-1:ACC_W], pend_add_ff[2*ACC_W-1:ACC_W]),
                    sat_add(rdata_ff[ACC_W-1:0], pend_add_ff[ACC_W-1:0])};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= cmd.valid && cmd.add;
      end
      pend_addr_ff <= cmd.addr;
      pend_add_ff  <= {cmd.blue, cmd.green, cmd.red};
   end

   // taps of one star hit distinct words and the sequencer drains before
   // the next item, so a read never meets a pending write to its word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.valid) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   assign clearing = clr_busy_ff;
   assign rd_red   = rdata_ff[ACC_W-1:0];
   assign rd_green = rdata_ff[2*ACC_W-1:ACC_W];
   assign rd_blue  = rdata_ff[3*ACC_W-1:2*ACC_W];

endmodule

`default_nettype wire

[hw/rtl/gss_checker.sv]
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks of the star splatting core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_checker import gss_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one item at a time: no accept right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted back to back");

   // a star that landed reports no pixel sums
   a_star_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[RSP_DATA_W-1:2*CNT_W] == '0)
      else $error("star result carries sums");

endmodule

bind gaussian_star_splat_core gss_checker u_gss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
